[hdl/dcd_pkg.sv]
// Shared types, constants and the month length table for the day count converter.
`default_nettype none

package dcd_pkg;

  // Calendar limits
  localparam logic [11:0] FIRST_YEAR  = 12'd1900;
  localparam logic [11:0] LAST_YEAR   = 12'd2099;
  localparam logic signed [17:0] LAST_SERIAL = 18'sd73049;
  localparam logic [8:0]  LEAP_DAYS   = 9'd366;
  localparam logic [8:0]  COMMON_DAYS = 9'd365;
  localparam logic [3:0]  LAST_MONTH  = 4'd12;
  // 1900 is year 0 of its century and year 300 of its 400-year cycle
  localparam logic [6:0]  START_MOD100 = 7'd0;
  localparam logic [8:0]  START_MOD400 = 9'd300;

  // Microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_LOW   = 3'd1;
  localparam step_t ST_HIGH  = 3'd2;
  localparam step_t ST_YEAR  = 3'd3;
  localparam step_t ST_MONTH = 3'd4;
  localparam step_t ST_MIN   = 3'd5;
  localparam step_t ST_MAX   = 3'd6;
  localparam step_t ST_OUT   = 3'd7;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_NONPOS,
    COND_OVER,
    COND_YEAR_END,
    COND_MONTH_END
  } cond_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SUB_YEAR,
    OP_SUB_MONTH,
    OP_SET_MIN,
    OP_SET_MAX
  } op_t;

  // One microcode word
  typedef struct packed {
    cond_t cond;
    op_t   op_true;
    op_t   op_false;
    step_t next_true;
    step_t next_false;
  } ctrl_word_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic nonpos;
    logic over;
    logic year_end;
    logic month_end;
  } dp_status_t;

  // Days in a month, month 1..12
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      case (month)
        4'd2:                      len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

[hdl/dcd_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module dcd_seq
  import dcd_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  dp_status_t status,
  output op_t        op,
  output logic       busy,
  output logic       done
);

  step_t      step;
  step_t      step_next;
  ctrl_word_t word;
  logic       taken;

  // Control store
  function automatic ctrl_word_t rom_word(input step_t s);
    ctrl_word_t w;
    begin
      case (s)
        ST_IDLE:  w = '{COND_START,     OP_LOAD,  OP_NOP,       ST_LOW,   ST_IDLE};
        ST_LOW:   w = '{COND_NONPOS,    OP_NOP,   OP_NOP,       ST_MIN,   ST_HIGH};
        ST_HIGH:  w = '{COND_OVER,      OP_NOP,   OP_NOP,       ST_MAX,   ST_YEAR};
        ST_YEAR:  w = '{COND_YEAR_END,  OP_NOP,   OP_SUB_YEAR,  ST_MONTH, ST_YEAR};
        ST_MONTH: w = '{COND_MONTH_END, OP_NOP,   OP_SUB_MONTH, ST_OUT,   ST_MONTH};
        ST_MIN:   w = '{COND_ALWAYS,    OP_SET_MIN, OP_NOP,     ST_OUT,   ST_OUT};
        ST_MAX:   w = '{COND_ALWAYS,    OP_SET_MAX, OP_NOP,     ST_OUT,   ST_OUT};
        ST_OUT:   w = '{COND_ALWAYS,    OP_NOP,   OP_NOP,       ST_IDLE,  ST_IDLE};
        default:  w = '{COND_ALWAYS,    OP_NOP,   OP_NOP,       ST_IDLE,  ST_IDLE};
      endcase
      return w;
    end
  endfunction

  assign word = rom_word(step);

  // Condition select
  always_comb begin
    case (word.cond)
      COND_ALWAYS:    taken = 1'b1;
      COND_START:     taken = start;
      COND_NONPOS:    taken = status.nonpos;
      COND_OVER:      taken = status.over;
      COND_YEAR_END:  taken = status.year_end;
      COND_MONTH_END: taken = status.month_end;
      default:        taken = 1'b1;
    endcase
  end

  assign op        = taken ? word.op_true : word.op_false;
  assign step_next = taken ? word.next_true : word.next_false;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign busy = (step != ST_IDLE);
  assign done = (step == ST_OUT);

endmodule

`default_nettype wire

[hdl/dcd_dp.sv]
// Datapath: remaining day count, year and month registers with leap tracking.
`default_nettype none

module dcd_dp
  import dcd_pkg::*;
(
  input  wire         clk,
  input  wire  [17:0] day_count,
  input  op_t         op,
  output dp_status_t  status,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  logic signed [17:0] rem;
  logic [6:0]         mod100;
  logic [8:0]         mod400;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;

  // Leap rule: by 400, or by 4 and not by 100
  assign leap = (mod400 == 9'd0) || ((mod100 != 7'd0) && (year[1:0] == 2'b00));
  assign ylen = leap ? LEAP_DAYS : COMMON_DAYS;
  assign mlen = month_len(month, leap);

  // Status for jumps
  assign status.nonpos    = rem[17] || (rem == 18'sd0);
  assign status.over      = rem > LAST_SERIAL;
  assign status.year_end  = (year == LAST_YEAR) || (rem <= $signed({9'd0, ylen}));
  assign status.month_end = (month == LAST_MONTH) || (rem <= $signed({13'd0, mlen}));

  // Working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        rem    <= $signed(day_count);
        year   <= FIRST_YEAR;
        month  <= 4'd1;
        mod100 <= START_MOD100;
        mod400 <= START_MOD400;
      end
      OP_SUB_YEAR: begin
        rem    <= rem - $signed({9'd0, ylen});
        year   <= year + 12'd1;
        mod100 <= (mod100 == 7'd99)  ? 7'd0 : mod100 + 7'd1;
        mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
      end
      OP_SUB_MONTH: begin
        rem   <= rem - $signed({13'd0, mlen});
        month <= month + 4'd1;
      end
      OP_SET_MIN: begin
        rem   <= 18'sd1;
        year  <= FIRST_YEAR;
        month <= 4'd1;
      end
      OP_SET_MAX: begin
        rem   <= 18'sd31;
        year  <= LAST_YEAR;
        month <= LAST_MONTH;
      end
      default: begin
      end
    endcase
  end

  assign day = rem[4:0];

endmodule

`default_nettype wire

[hdl/day_count_to_date.sv]
// Top level: serial day count to Gregorian date, microcoded.
//
//   channel   signals                              handshake
//   request   start, day_count                     taken when start & !busy
//   result    done, year_out, month_out, day_out   one-cycle strobe on done
//
// One request at a time. After the count is loaded the microprogram checks it
// against both ends of the range, then its year and month subtract loops take
// whole years and then whole months off the count before the result is shown;
// a count of zero or less, or past the end of 2099, is clamped instead.
// Synchronous reset returns the step counter to idle; no clearing pass.
// The result is shown for one cycle and cannot be held off.
`default_nettype none

module day_count_to_date
  import dcd_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [17:0] day_count,
  output logic        busy,
  output logic        done,
  output logic [11:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out
);

  op_t        op;
  dp_status_t status;

  // Sequencer
  dcd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy),
    .done   (done)
  );

  // Datapath
  dcd_dp u_dp (
    .clk       (clk),
    .day_count (day_count),
    .op        (op),
    .status    (status),
    .year      (year_out),
    .month     (month_out),
    .day       (day_out)
  );

endmodule

`default_nettype wire

[hdl/dcd_chk.sv]
// Port-level checker for the day count converter, bound to the top level.
`default_nettype none

module dcd_chk (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire [17:0] day_count,
  input wire        busy,
  input wire        done,
  input wire [11:0] year_out,
  input wire [3:0]  month_out,
  input wire [4:0]  day_out
);

  // A result only appears while a request is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // An accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but not busy");

  // The block frees up right after its result
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("still busy after result");

  // Results stay within the calendar range
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (year_out >= 12'd1900) && (year_out <= 12'd2099) &&
             (month_out >= 4'd1) && (month_out <= 4'd12) &&
             (day_out >= 5'd1) && (day_out <= 5'd31))
    else $error("result out of range");

endmodule

bind day_count_to_date dcd_chk u_chk (.*);

`default_nettype wire
